### rtl/hds_pkg.sv
package hds_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int MAX_GRID   = 1024;
    localparam int IDX_W      = $clog2(MAX_GRID);
    localparam int GRID_W     = IDX_W + 1;
    localparam int LAMBDA_W   = 16;
    localparam int FRAC_SHIFT = 16;
    localparam int SUM_W      = SAMPLE_W + 3;
    localparam int PROD_W     = SUM_W + LAMBDA_W + 1;
    localparam int SAT_W      = PROD_W - FRAC_SHIFT + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [GRID_W-1:0]   GRID_MIN     = GRID_W'(3);
    localparam logic [GRID_W-1:0]   GRID_MAX     = GRID_W'(MAX_GRID);
    localparam logic [GRID_W-1:0]   GRID_RESET   = GRID_W'(MAX_GRID);
    localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = LAMBDA_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_SIZE = 1'b0,
        CFG_LAMBDA    = 1'b1
    } t_cfg_reg;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] column;
        logic             last;
    } t_tag;

endpackage

### rtl/hds_line_buffer.sv
module hds_line_buffer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [hds_pkg::IDX_W-1:0] i_addr,
    input  hds_pkg::t_sample         i_sample,
    output hds_pkg::t_sample         o_mid,
    output hds_pkg::t_sample         o_up
);
    import hds_pkg::*;

    t_sample          recent_mem [MAX_GRID];
    t_sample          older_mem  [MAX_GRID];
    t_sample          r_mid;
    t_sample          r_up;
    logic             r_wr_pend;
    logic [IDX_W-1:0] r_wr_addr;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_mid              <= recent_mem[i_addr];
            r_up               <= older_mem[i_addr];
            recent_mem[i_addr] <= i_sample;
        end
    end

    // move the row read on the last transfer down into the older store
    always_ff @(posedge i_clk) begin
        if (r_wr_pend) begin
            older_mem[r_wr_addr] <= r_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= i_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_wr_addr <= i_addr;
        end
    end

    assign o_mid = r_mid;
    assign o_up  = r_up;

endmodule

### rtl/heat_diffusion_stencil_step.sv
// A completed result passes the read, window, sum, multiply and saturate registers in turn.
// Throughput: one sample per cycle unless i_out_ready stalls the output; the two line store ports and stages set it.
// Stages: line store read, window, stencil sum, lambda multiply, add and saturate.
// Reset (synchronous, active low) clears valids, counters and window and loads
// grid_size = 1024, lambda_q16 = 16384; line stores are not cleared and need no pass.
module heat_diffusion_stencil_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hds_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hds_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [hds_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [hds_pkg::SAMPLE_W-1:0] o_new_value,
    output logic [hds_pkg::IDX_W-1:0]           o_row,
    output logic [hds_pkg::IDX_W-1:0]           o_column,
    output logic                                o_last_of_grid
);
    import hds_pkg::*;

    logic [GRID_W-1:0]   r_grid;
    logic [LAMBDA_W-1:0] r_lambda;
    logic [IDX_W-1:0]    r_row;
    logic [IDX_W-1:0]    r_col;
    logic [IDX_W-1:0]    n_row;
    logic [IDX_W-1:0]    n_col;
    logic [GRID_W-1:0]   n_grid;

    logic cfg_wr;
    logic accept;
    logic en1, en2, en3, en4, en5;
    logic row_end, col_end, produce;
    t_tag tag0;

    t_sample mid;
    t_sample up;

    logic    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic    r_prod1;
    t_tag    r_tag1, r_tag2, r_tag3, r_tag4, r_tag5;
    t_sample r_x1;
    t_sample r_win [6];
    t_sample r_left, r_center2, r_right, r_upper, r_down;
    t_sample r_center3, r_center4;
    t_sample r_value5;

    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [SAT_W-1:0]  full_value;
    t_sample                  n_value;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready = en1;
    assign accept     = i_in_valid && o_in_ready;

    assign col_end = ({1'b0, r_col} == r_grid - GRID_W'(1));
    assign row_end = ({1'b0, r_row} == r_grid - GRID_W'(1));
    assign produce = (r_row >= IDX_W'(2)) && (r_col >= IDX_W'(2));

    always_comb begin
        tag0.row    = r_row - IDX_W'(1);
        tag0.column = r_col - IDX_W'(1);
        tag0.last   = row_end && col_end;
    end

    always_comb begin
        n_grid = i_cfg_data[GRID_W-1:0];
        if (n_grid < GRID_MIN) begin
            n_grid = GRID_MIN;
        end else if (n_grid > GRID_MAX) begin
            n_grid = GRID_MAX;
        end
    end

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + IDX_W'(1);
            end else begin
                n_col = r_col + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid   <= GRID_RESET;
            r_lambda <= LAMBDA_RESET;
            r_row    <= '0;
            r_col    <= '0;
        end else if (cfg_wr) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_GRID_SIZE: begin
                    r_grid <= n_grid;
                    r_row  <= '0;
                    r_col  <= '0;
                end
                CFG_LAMBDA: begin
                    r_lambda <= i_cfg_data[LAMBDA_W-1:0];
                end
                default: begin
                end
            endcase
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    hds_line_buffer u_line_buffer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_addr   (r_col),
        .i_sample (i_sample),
        .o_mid    (mid),
        .o_up     (up)
    );

    always_comb begin
        n_sum = SUM_W'(r_upper) + SUM_W'(r_down) + SUM_W'(r_left) + SUM_W'(r_right)
              - (SUM_W'(r_center2) <<< 2);
        n_prod = PROD_W'(r_sum) * PROD_W'($signed({1'b0, r_lambda}));
        full_value = SAT_W'(r_center4) + SAT_W'(r_prod >>> FRAC_SHIFT);
        if (full_value[SAT_W-1:SAMPLE_W-1] == '0 || full_value[SAT_W-1:SAMPLE_W-1] == '1) begin
            n_value = full_value[SAMPLE_W-1:0];
        end else if (full_value[SAT_W-1]) begin
            n_value = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            n_value = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= accept;
            if (en2) r_v2 <= r_v1 && r_prod1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    // shift the window as each sample leaves the read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_v1 && en2) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= mid;
            r_win[3] <= r_win[4];
            r_win[4] <= up;
            r_win[5] <= r_x1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x1    <= i_sample;
            r_prod1 <= produce;
            r_tag1  <= tag0;
        end
        if (en2) begin
            r_left    <= r_win[1];
            r_center2 <= r_win[2];
            r_right   <= mid;
            r_upper   <= r_win[4];
            r_down    <= r_win[5];
            r_tag2    <= r_tag1;
        end
        if (en3) begin
            r_sum     <= n_sum;
            r_center3 <= r_center2;
            r_tag3    <= r_tag2;
        end
        if (en4) begin
            r_prod    <= n_prod;
            r_center4 <= r_center3;
            r_tag4    <= r_tag3;
        end
        if (en5) begin
            r_value5 <= n_value;
            r_tag5   <= r_tag4;
        end
    end

    assign o_out_valid    = r_v5;
    assign o_new_value    = r_value5;
    assign o_row          = r_tag5.row;
    assign o_column       = r_tag5.column;
    assign o_last_of_grid = r_tag5.last;

`ifndef SYNTHESIS
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_row != '0) && (o_column != '0))
        else $error("result outside the grid interior");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_of_grid |->
            (o_row == o_column) && ({1'b0, o_row} == r_grid - GRID_W'(2)))
        else $error("last mark away from the final interior point");

    a_counters_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_row} < r_grid) && ({1'b0, r_col} < r_grid))
        else $error("position counter beyond grid size");
`endif

endmodule
